// ===== rtl/fqs_pkg.sv =====
// Shared types and constants of the queue with search.
package fqs_pkg;

	localparam int unsigned QDEPTH = 16;
	localparam int unsigned CW = $clog2(QDEPTH + 1);
	localparam int unsigned VALUE_W = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                kind;
		logic [VALUE_W-1:0]   value;
	} req_item_t;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   read_value;
		logic                 found;
		logic [CW-1:0]        position;
		logic [CW-1:0]        occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== rtl/fqs_if.sv =====
// Valid/ready channel carrying one item per transfer.
interface fqs_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fqs_cell.sv =====
// One storage cell of the queue: holds an entry, shifts toward the head, compares.
module fqs_cell import fqs_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] next_entry,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic                  live,
	input  logic                  hit_in,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  hit_out,
	output logic                  first
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  match;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= next_entry;
		end else if (ctl.load) begin
			entry_q <= word;
		end
	end

	// An earlier match further up the chain masks this one.
	assign match   = live && (entry_q == word);
	assign first   = match && !hit_in;
	assign hit_out = hit_in || match;
	assign entry   = entry_q;

endmodule

// ===== rtl/fifo_queue_with_search_unit.sv =====
// Top level of the bounded queue with search, built as a chain of storage cells.
//
// The block takes operations on the req channel (kind and value) and returns one
// result per operation on the rsp channel. An insert appends the value at the tail
// or reports full, a remove returns the head word or reports empty, and a search
// reports whether the value is held and the position of its first match from the
// head. Every result carries the occupancy after the operation.
//
// Every cell compares its entry with the search word at once, and on a remove
// every cell takes its neighbor's entry in the same clock. The result is
// captured in an output register on the req transfer, and a new operation is
// taken in every cycle while rsp is drained, so the throughput is one item per
// cycle.
//
// When the receiver stalls, the result is held in the output register and req
// ready drops until the rsp transfer happens; a transfer on both sides in one
// cycle keeps the rate. Reset clears the fill count and the output valid; the
// entries themselves are not cleared, since only occupied cells are ever read.
module fifo_queue_with_search_unit import fqs_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	fqs_if.sink   req,
	fqs_if.source rsp
);

	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] entry_w [QDEPTH+1];
	logic                  hit_w [QDEPTH+1];
	logic [QDEPTH-1:0]     first_w;
	cell_ctl_t             ctl_w [QDEPTH];
	logic [CW-1:0]         match_pos;
	logic                  any_hit;
	logic                  do_insert;
	logic                  do_remove;
	logic [CW-1:0]         count_d;
	rsp_item_t             rsp_d;

	// A new operation is taken whenever the output register is free or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign word      = DATA_WIDTH'(req.payload.value);

	assign entry_w[QDEPTH] = word;
	assign hit_w[0]        = 1'b0;

	for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
		assign ctl_w[i].shift = do_remove;
		assign ctl_w[i].load  = do_insert && (count_q == CW'(i));

		fqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk        (clk),
			.ctl        (ctl_w[i]),
			.next_entry (entry_w[i+1]),
			.word       (word),
			.live       (CW'(i) < count_q),
			.hit_in     (hit_w[i]),
			.entry      (entry_w[i]),
			.hit_out    (hit_w[i+1]),
			.first      (first_w[i])
		);
	end

	assign any_hit = hit_w[QDEPTH];

	// At most one cell flags the first match, so the position is an OR of indexes.
	always_comb begin
		match_pos = '0;
		for (int i = 0; i < QDEPTH; i++) begin
			if (first_w[i]) begin
				match_pos = match_pos | CW'(i);
			end
		end
	end

	always_comb begin
		do_insert        = 1'b0;
		do_remove        = 1'b0;
		count_d          = count_q;
		rsp_d.status     = ST_OK;
		rsp_d.read_value = '0;
		rsp_d.found      = 1'b0;
		rsp_d.position   = '0;
		case (req.payload.kind)
			KIND_INSERT: begin
				if (count_q == CW'(QDEPTH)) begin
					rsp_d.status = ST_FULL;
				end else begin
					do_insert = accept;
					count_d   = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (count_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					do_remove        = accept;
					count_d          = count_q - CW'(1);
					rsp_d.read_value = VALUE_W'(entry_w[0]);
				end
			end
			KIND_SEARCH: begin
				rsp_d.found    = any_hit;
				rsp_d.position = any_hit ? match_pos : count_q;
			end
			default: begin
				// The unused code leaves the queue untouched and reports success.
			end
		endcase
		rsp_d.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// The fill count never goes past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("fill count exceeds queue depth");

	// A successful insert grows the queue by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.payload.kind == KIND_INSERT && count_q != CW'(QDEPTH)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance the fill count");

	// A successful remove returns what the head cell held.
	a_remove_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.payload.kind == KIND_REMOVE && count_q != '0
		|=> rsp_q.read_value == $past(VALUE_W'(entry_w[0])))
		else $error("removed word differs from the head entry");

	// A match always lies inside the occupied part of the queue.
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.found |-> rsp_q.position < rsp_q.occupancy)
		else $error("search position outside the occupied entries");

endmodule

// ===== dv/fqs_checker.sv =====
// Checker for the queue with search: predicts every result from the accepted operations.
module fqs_checker import fqs_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req_item,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp_item,
	output int        errors,
	output int        pending
);

	localparam logic [VALUE_W-1:0] WORD_MASK = VALUE_W'((64'd1 << DATA_WIDTH) - 64'd1);

	logic [VALUE_W-1:0] words [QDEPTH];
	int unsigned        held;
	rsp_item_t          expected_rsp [$];

	// Applies one operation to the mirrored queue and returns the result it must give.
	function automatic rsp_item_t queue_step(input req_item_t op);
		rsp_item_t          r;
		logic [VALUE_W-1:0] w;
		r = '0;
		r.status = ST_OK;
		w = op.value & WORD_MASK;
		case (op.kind)
			KIND_INSERT: begin
				if (held >= QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					words[held] = w;
					held++;
				end
			end
			KIND_REMOVE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = words[0];
					for (int i = 1; i < held; i++) words[i-1] = words[i];
					held--;
				end
			end
			KIND_SEARCH: begin
				r.position = CW'(held);
				for (int i = 0; i < held; i++) begin
					if (!r.found && words[i] == w) begin
						r.found = 1'b1;
						r.position = CW'(i);
					end
				end
			end
			default: begin
			end
		endcase
		r.occupancy = CW'(held);
		return r;
	endfunction

	task automatic report(input string field, input logic [63:0] exp, input logic [63:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t exp;
		if (!arst_n) begin
			held = 0;
			expected_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %p",
						$time, rsp_item);
					errors++;
				end else begin
					exp = expected_rsp.pop_front();
					report("status", exp.status, rsp_item.status);
					report("read_value", exp.read_value, rsp_item.read_value);
					report("found", exp.found, rsp_item.found);
					report("position", exp.position, rsp_item.position);
					report("occupancy", exp.occupancy, rsp_item.occupancy);
				end
			end
			if (req_valid && req_ready) expected_rsp.push_back(queue_step(req_item));
			pending = expected_rsp.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the queue with search: drives operations and gives the verdict.
module tb_top;
	import fqs_pkg::*;

	// Cycles without any transfer on either side before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below plus a sender gap.
	localparam int STALL_LIMIT = 1000;
	// Length of the long receiver hold-off that makes the block back up its input.
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1640;
	// In the last stretch of the run neither side idles.
	localparam int QUIET_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fqs_if #(.item_t(req_item_t)) req_ch ();
	fqs_if #(.item_t(rsp_item_t)) rsp_ch ();

	int errors;
	int pending;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	// A small set of words, several of which share their low byte, so that searches
	// hit often, duplicates appear, and a compare on too few bits would be caught.
	logic [VALUE_W-1:0] word_pool [8] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h0000_00FF, 32'h1234_00FF, 32'h8000_0000, 32'h0000_0001
	};

	fifo_queue_with_search_unit #(.DATA_WIDTH(32)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fqs_checker #(.DATA_WIDTH(32)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_item  (req_ch.payload),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_item  (rsp_ch.payload),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Reset is applied once and released at a rising edge.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The watchdog ends a run in which no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offers one operation and returns once it has been transferred. Before the offer
	// the sender may go idle for a burst, which drops valid for those cycles. When no
	// gap is taken, valid stays high straight into the next item with one assignment.
	task automatic offer(input logic [1:0] kind, input logic [VALUE_W-1:0] value);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= '{kind: kind_t'(kind), value: value};
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Picks a word for an insert or a search. Searches also get near misses: a pool
	// word with one bit flipped above the low byte, which only a full-width compare
	// tells apart from the pool word itself.
	function automatic logic [VALUE_W-1:0] pick_word(input bit for_search);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return word_pool[$urandom_range(0, 7)];
		if (for_search && roll < 80)
			return word_pool[$urandom_range(0, 7)] ^ (32'h1 << $urandom_range(8, 31));
		return $urandom;
	endfunction

	// Chooses the next operation. A fill phase leans toward inserts so the queue
	// reaches full and inserts are refused; a drain phase leans toward removes so
	// the queue empties; a balanced phase stays around the middle. The unused
	// operation code shows up now and then in every phase.
	function automatic logic [1:0] pick_kind(input int phase);
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned rem_pct;
		roll = $urandom_range(0, 99);
		case (phase)
			0: begin ins_pct = 60; rem_pct = 15; end
			1: begin ins_pct = 20; rem_pct = 55; end
			default: begin ins_pct = 40; rem_pct = 30; end
		endcase
		if (roll < ins_pct) return KIND_INSERT;
		if (roll < ins_pct + rem_pct) return KIND_REMOVE;
		if (roll < 97) return KIND_SEARCH;
		return KIND_NOP;
	endfunction

	// Receiver: ready comes in random runs, broken by stall bursts.
	// Once, on request from the sender, it holds off for a long stretch so that the
	// result register stays occupied and the block has to stall its input.
	initial begin
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Sender: a short directed run, then random phases, then the drain and the verdict.
	initial begin
		logic [1:0] kind;
		int         phase;
		int         phase_left;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		do @(posedge clk); while (!arst_n);

		// Operations on the empty queue, including the unused operation code.
		offer(KIND_REMOVE, 32'hFFFF_FFFF);
		offer(KIND_SEARCH, 32'h0000_0000);
		offer(KIND_NOP, 32'hFFFF_FFFF);
		// Extreme words, searches that hit at the head and further in, a miss that
		// matches only in the low byte, and a duplicate where the first match counts.
		offer(KIND_INSERT, 32'h0000_0000);
		offer(KIND_INSERT, 32'hFFFF_FFFF);
		offer(KIND_INSERT, 32'h0000_00FF);
		offer(KIND_SEARCH, 32'hFFFF_FFFF);
		offer(KIND_SEARCH, 32'h0000_0000);
		offer(KIND_SEARCH, 32'h1234_00FF);
		offer(KIND_INSERT, 32'h0000_0000);
		offer(KIND_SEARCH, 32'h0000_0000);
		offer(KIND_NOP, 32'h0000_0000);
		// Removes return the words in order, down to a remove on the emptied queue.
		offer(KIND_REMOVE, 32'h0);
		offer(KIND_REMOVE, 32'h0);
		offer(KIND_SEARCH, 32'h0000_0000);
		offer(KIND_REMOVE, 32'h0);
		offer(KIND_REMOVE, 32'h0);
		offer(KIND_REMOVE, 32'h0);
		offer(KIND_SEARCH, 32'hFFFF_FFFF);

		phase = 0;
		phase_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			// The long hold-off falls a third of the way into the run, during traffic.
			if (n == RANDOM_ITEMS / 3) hold_request = 1'b1;
			if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
			kind = pick_kind(phase);
			case (kind)
				KIND_INSERT: offer(kind, pick_word(1'b0));
				KIND_SEARCH: offer(kind, pick_word(1'b1));
				default: offer(kind, $urandom);
			endcase
		end
		req_ch.valid <= 1'b0;

		// Wait for every outstanding result, then keep the clock running so that any
		// stray result would still be seen; the watchdog bounds this wait. A result
		// still owed at the end also fails the run.
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fqs_pkg.sv
rtl/fqs_if.sv
rtl/fqs_cell.sv
rtl/fifo_queue_with_search_unit.sv
dv/fqs_checker.sv
dv/tb_top.sv
